// ----- rtl/sti_pkg.sv -----
`default_nettype none

package sti_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_X0_RD,
      ST_X0_CK,
      ST_XL_RD,
      ST_XL_CK,
      ST_SCAN_RD,
      ST_SCAN_CK,
      ST_STEP,
      ST_YA,
      ST_YB,
      ST_DIV,
      ST_APPLY,
      ST_MUL
   } state_type;

   typedef enum logic [2:0] {
      OP_LOAD,
      OP_T,
      OP_SUBT,
      OP_P,
      OP_MUL,
      OP_EN,
      OP_ENT,
      OP_ENF
   } op_type;

   typedef struct packed {
      logic [2:0] col;
      op_type     op;
      logic       last;
   } step_type;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   localparam logic REG_ROWS_IN_USE = 1'b0;

   localparam logic [3:0] CODE_OTHER = 4'd0;
   localparam logic [3:0] CODE_HEVAP = 4'd7;
   localparam logic [3:0] CODE_SEVAP = 4'd8;
   localparam logic [3:0] CODE_UVAP  = 4'd9;
   localparam logic [3:0] CODE_ULIQ  = 4'd10;
   localparam logic [3:0] CODE_UEVAP = 4'd11;
   localparam logic [3:0] CODE_LAST  = 4'd11;

   localparam logic [2:0] COL_TEMP = 3'd0;
   localparam logic [2:0] COL_PRES = 3'd1;
   localparam logic [2:0] COL_VLIQ = 3'd2;
   localparam logic [2:0] COL_VVAP = 3'd3;
   localparam logic [2:0] COL_HLIQ = 3'd4;
   localparam logic [2:0] COL_HVAP = 3'd5;
   localparam logic [2:0] COL_SLIQ = 3'd6;
   localparam logic [2:0] COL_SVAP = 3'd7;

   function automatic step_type mk_step(logic [2:0] col, op_type op, logic last);
      step_type s;
      s.col  = col;
      s.op   = op;
      s.last = last;
      return s;
   endfunction

   // Lookup program of each property code: column to fetch and what to do with it.
   function automatic step_type prog_step(logic [3:0] code, logic kc, logic [2:0] idx);
      step_type s;
      s = mk_step(COL_TEMP, OP_LOAD, 1'b1);
      unique case (code)
         CODE_OTHER: begin
            s = mk_step(kc ? COL_TEMP : COL_PRES, OP_LOAD, 1'b1);
         end
         CODE_HEVAP: begin
            if (idx == 3'd0) s = mk_step(COL_HVAP, OP_T, 1'b0);
            else s = mk_step(COL_HLIQ, OP_SUBT, 1'b1);
         end
         CODE_SEVAP: begin
            if (idx == 3'd0) s = mk_step(COL_SVAP, OP_T, 1'b0);
            else s = mk_step(COL_SLIQ, OP_SUBT, 1'b1);
         end
         CODE_UVAP: begin
            case (idx)
               3'd0:    s = mk_step(COL_PRES, OP_P, 1'b0);
               3'd1:    s = mk_step(COL_VVAP, OP_MUL, 1'b0);
               default: s = mk_step(COL_HVAP, OP_EN, 1'b1);
            endcase
         end
         CODE_ULIQ: begin
            case (idx)
               3'd0:    s = mk_step(COL_PRES, OP_P, 1'b0);
               3'd1:    s = mk_step(COL_VLIQ, OP_MUL, 1'b0);
               default: s = mk_step(COL_HLIQ, OP_EN, 1'b1);
            endcase
         end
         CODE_UEVAP: begin
            case (idx)
               3'd0:    s = mk_step(COL_PRES, OP_P, 1'b0);
               3'd1:    s = mk_step(COL_VVAP, OP_MUL, 1'b0);
               3'd2:    s = mk_step(COL_HVAP, OP_ENT, 1'b0);
               3'd3:    s = mk_step(COL_VLIQ, OP_MUL, 1'b0);
               default: s = mk_step(COL_HLIQ, OP_ENF, 1'b1);
            endcase
         end
         default: begin
            s = mk_step(3'(code + 4'd1), OP_LOAD, 1'b1);
         end
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/sti_table.sv -----
`default_nettype none

module sti_table #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10,
   parameter int DW    = 48
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [DW-1:0] wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/sti_muldiv.sv -----
`default_nettype none

// floor(num * mult / den) with num < den, one multiplier bit at a time: a doubling phase, then an add phase.
module sti_muldiv #(
   parameter int W = 49
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [W-1:0] num,
   input  wire logic [W-1:0] den,
   input  wire logic [W-1:0] mult,
   output logic              done,
   output logic      [W-1:0] quot
);

   localparam int CNTW = $clog2(W + 1);

   logic            busy_ff, busy_in;
   logic            phase_ff, phase_in;
   logic            done_ff, done_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]    mult_ff, mult_in;
   logic [W-1:0]    num_ff, num_in;
   logic [W-1:0]    den_ff, den_in;
   logic [W-1:0]    q_ff, q_in;
   logic [W:0]      r_ff, r_in;
   logic [W:0]      r2;
   logic [W:0]      t;

   always_comb begin
      busy_in  = busy_ff;
      phase_in = phase_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      mult_in  = mult_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      q_in     = q_ff;
      r_in     = r_ff;
      r2       = {r_ff[W-1:0], 1'b0};
      t        = r_ff + {1'b0, (mult_ff[W-1] ? num_ff : {W{1'b0}})};
      if (start) begin
         busy_in  = 1'b1;
         phase_in = 1'b0;
         cnt_in   = '0;
         mult_in  = mult;
         num_in   = num;
         den_in   = den;
         q_in     = '0;
         r_in     = '0;
      end else if (busy_ff) begin
         if (!phase_ff) begin
            // double the partial value
            if (r2 >= {1'b0, den_ff}) begin
               r_in = r2 - {1'b0, den_ff};
               q_in = {q_ff[W-2:0], 1'b0} + W'(1);
            end else begin
               r_in = r2;
               q_in = {q_ff[W-2:0], 1'b0};
            end
            phase_in = 1'b1;
         end else begin
            // add num where the multiplier bit is set
            if (t >= {1'b0, den_ff}) begin
               r_in = t - {1'b0, den_ff};
               q_in = q_ff + W'(1);
            end else begin
               r_in = t;
            end
            mult_in  = {mult_ff[W-2:0], 1'b0};
            phase_in = 1'b0;
            cnt_in   = cnt_ff + CNTW'(1);
            if (cnt_ff == CNTW'(W - 1)) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         phase_ff <= 1'b0;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         busy_ff  <= busy_in;
         phase_ff <= phase_in;
         done_ff  <= done_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mult_ff <= mult_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      q_ff    <= q_in;
      r_ff    <= r_in;
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

`default_nettype wire

// ----- rtl/sti_fxmul.sv -----
`default_nettype none

// (a * b) >> F, truncated toward zero and saturated; shift-add one bit a cycle.
module sti_fxmul #(
   parameter int W = 48,
   parameter int F = 24
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [W-1:0] a_val,
   input  wire logic [W-1:0] b_val,
   output logic              done,
   output logic      [W-1:0] prod
);

   localparam int CNTW = $clog2(W + 1);

   logic            busy_ff, busy_in;
   logic            fin_ff, fin_in;
   logic            done_ff, done_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic            neg_ff, neg_in;
   logic [W-1:0]    ma_ff, ma_in;
   logic [W-1:0]    hi_ff, hi_in;
   logic [W-1:0]    lo_ff, lo_in;
   logic [W-1:0]    res_ff, res_in;
   logic [W:0]      sum;
   logic [2*W-1:0]  scaled;
   logic            upper_or;
   logic            low_or;

   always_comb begin
      busy_in  = busy_ff;
      fin_in   = 1'b0;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      neg_in   = neg_ff;
      ma_in    = ma_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      res_in   = res_ff;
      sum      = {1'b0, hi_ff} + {1'b0, (lo_ff[0] ? ma_ff : {W{1'b0}})};
      scaled   = {hi_ff, lo_ff} >> F;
      upper_or = |scaled[2*W-1:W];
      low_or   = |scaled[W-2:0];
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         neg_in  = a_val[W-1] ^ b_val[W-1];
         ma_in   = a_val[W-1] ? (W'(0) - a_val) : a_val;
         lo_in   = b_val[W-1] ? (W'(0) - b_val) : b_val;
         hi_in   = '0;
      end else if (busy_ff) begin
         hi_in  = sum[W:1];
         lo_in  = {sum[0], lo_ff[W-1:1]};
         cnt_in = cnt_ff + CNTW'(1);
         if (cnt_ff == CNTW'(W - 1)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end else if (fin_ff) begin
         done_in = 1'b1;
         if (neg_ff) begin
            if (upper_or || (scaled[W-1] && low_or)) begin
               res_in = {1'b1, {(W-1){1'b0}}};
            end else begin
               res_in = W'(0) - scaled[W-1:0];
            end
         end else begin
            if (upper_or || scaled[W-1]) begin
               res_in = {1'b0, {(W-1){1'b1}}};
            end else begin
               res_in = scaled[W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      ma_ff  <= ma_in;
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
      res_ff <= res_in;
   end

   assign done = done_ff;
   assign prod = res_ff;

endmodule

`default_nettype wire

// ----- rtl/saturation_table_interpolator.sv -----
`default_nettype none

// Saturation table interpolator. Cell writes take effect at the accepting edge and
// keep busy low. A query with an undefined code is answered with zero, flagged out
// of range. Otherwise a query searches the key column one row at a time, a read
// state and then a check state per row (one table read port with registered data),
// then runs each needed column lookup: an exact hit uses the read row directly, an
// interpolation runs the bit-serial multiply-divide, and each p*v product runs the
// serial multiplier. The result shows for one cycle on rsp_strobe; the receiver
// cannot stall it, so sample it then.
module saturation_table_interpolator #(
   parameter int MAX_ROWS  = 128,
   parameter int FRAC_BITS = 24,
   parameter int WORD_BITS = 48
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic                        req_func,
   input  wire logic [6:0]                  req_row_index,
   input  wire logic [2:0]                  req_column_index,
   input  wire logic signed [WORD_BITS-1:0] req_cell_value,
   input  wire logic                        req_key_is_pressure,
   input  wire logic [3:0]                  req_property_code,
   input  wire logic signed [WORD_BITS-1:0] req_key_value,
   output logic                             rsp_strobe,
   output logic signed [WORD_BITS-1:0]      rsp_property_value,
   output logic                             rsp_out_of_range,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [2:0]                  paddr,
   input  wire logic [31:0]                 pwdata,
   output logic      [31:0]                 prdata,
   output logic                             pready
);

   localparam int W     = WORD_BITS;
   localparam int MW    = WORD_BITS + 1;
   localparam int RB    = (MAX_ROWS > 2) ? $clog2(MAX_ROWS) : 1;
   localparam int AW    = RB + 3;
   localparam int DEPTH = MAX_ROWS * 8;
   localparam int CW    = ((RB > 8) ? RB : 8) + 1;

   function automatic logic [W-1:0] sat_sub(logic [W-1:0] a, logic [W-1:0] b);
      logic [W:0] d;
      d = {a[W-1], a} - {b[W-1], b};
      if (d[W] != d[W-1]) begin
         return d[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end
      return d[W-1:0];
   endfunction

   sti_pkg::state_type state_ff, state_in;

   logic [7:0]              rows_ff;
   logic                    kc_ff, kc_in;
   logic [3:0]              code_ff, code_in;
   logic signed [W-1:0]     key_ff, key_in;
   logic signed [W-1:0]     xprev_ff, xprev_in;
   logic [RB-1:0]           row_ff, row_in;
   logic                    exact_ff, exact_in;
   logic                    flag_ff, flag_in;
   logic [2:0]              idx_ff, idx_in;
   logic [MW-1:0]           num_ff, num_in;
   logic [MW-1:0]           den_ff, den_in;
   logic [W-1:0]            ya_ff, ya_in;
   logic [W-1:0]            y_ff, y_in;
   logic [W-1:0]            t_ff, t_in;
   logic [W-1:0]            p_ff, p_in;
   logic [W-1:0]            m_ff, m_in;
   logic                    dneg_ff, dneg_in;
   logic                    rsp_strobe_ff, rsp_strobe_in;
   logic [W-1:0]            rsp_value_ff, rsp_value_in;
   logic                    rsp_oor_ff, rsp_oor_in;

   logic [CW-1:0]           rows_ext;
   logic [CW-1:0]           wr_row_ext;
   logic [RB-1:0]           last_row;
   logic                    accept;
   logic                    tbl_wr_en;
   logic [AW-1:0]           tbl_wr_addr;
   logic [AW-1:0]           tbl_rd_addr;
   logic [RB-1:0]           rd_row;
   logic [2:0]              rd_col;
   logic [W-1:0]            tbl_rd_data;
   logic signed [W-1:0]     x_rd;
   sti_pkg::step_type       step;
   logic [MW-1:0]           dy;
   logic                    md_start;
   logic [MW-1:0]           md_mult;
   logic                    md_done;
   logic [MW-1:0]           md_quot;
   logic                    fx_start;
   logic                    fx_done;
   logic [W-1:0]            fx_prod;
   logic [W-1:0]            op_res;

   assign accept     = start && !busy;
   assign busy       = (state_ff != sti_pkg::ST_IDLE);
   assign rows_ext   = CW'(rows_ff);
   assign wr_row_ext = CW'(req_row_index);
   assign x_rd       = tbl_rd_data;
   assign step       = sti_pkg::prog_step(code_ff, kc_ff, idx_ff);

   always_comb begin
      if (rows_ext < CW'(2)) begin
         last_row = RB'(1);
      end else if (rows_ext > CW'(MAX_ROWS)) begin
         last_row = RB'(MAX_ROWS - 1);
      end else begin
         last_row = RB'(rows_ext - CW'(1));
      end
   end

   // configuration port
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= 8'd74;
      end else if (psel && penable && pwrite && pready
                   && (paddr[2] == sti_pkg::REG_ROWS_IN_USE)) begin
         rows_ff <= pwdata[7:0];
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr[2] == sti_pkg::REG_ROWS_IN_USE) ? {24'd0, rows_ff} : 32'd0;

   // table
   assign tbl_wr_en   = accept && (req_func == sti_pkg::FUNC_WRITE)
                        && (wr_row_ext < CW'(MAX_ROWS));
   assign tbl_wr_addr = {wr_row_ext[RB-1:0], req_column_index};
   assign tbl_rd_addr = {rd_row, rd_col};

   always_comb begin
      rd_row = row_ff;
      rd_col = step.col;
      unique case (state_ff)
         sti_pkg::ST_X0_RD: begin
            rd_row = '0;
            rd_col = {2'b00, kc_ff};
         end
         sti_pkg::ST_XL_RD: begin
            rd_row = last_row;
            rd_col = {2'b00, kc_ff};
         end
         sti_pkg::ST_SCAN_RD: begin
            rd_row = row_ff;
            rd_col = {2'b00, kc_ff};
         end
         sti_pkg::ST_STEP: begin
            rd_row = exact_ff ? row_ff : (row_ff - RB'(1));
            rd_col = step.col;
         end
         default: begin
            rd_row = row_ff;
            rd_col = step.col;
         end
      endcase
   end

   sti_table #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .DW    (W)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (req_cell_value),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data)
   );

   assign dy      = {tbl_rd_data[W-1], tbl_rd_data} - {ya_ff[W-1], ya_ff};
   assign md_mult = dy[MW-1] ? (MW'(0) - dy) : dy;

   sti_muldiv #(
      .W (MW)
   ) u_muldiv (
      .clock (clock),
      .reset (reset),
      .start (md_start),
      .num   (num_ff),
      .den   (den_ff),
      .mult  (md_mult),
      .done  (md_done),
      .quot  (md_quot)
   );

   sti_fxmul #(
      .W (W),
      .F (FRAC_BITS)
   ) u_fxmul (
      .clock (clock),
      .reset (reset),
      .start (fx_start),
      .a_val (y_ff),
      .b_val (p_ff),
      .done  (fx_done),
      .prod  (fx_prod)
   );

   always_comb begin
      op_res = y_ff;
      case (step.op) inside
         sti_pkg::OP_SUBT: op_res = sat_sub(t_ff, y_ff);
         sti_pkg::OP_EN,
         sti_pkg::OP_ENT:  op_res = sat_sub(y_ff, m_ff);
         sti_pkg::OP_ENF:  op_res = sat_sub(t_ff, sat_sub(y_ff, m_ff));
         default:          op_res = y_ff;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      kc_in         = kc_ff;
      code_in       = code_ff;
      key_in        = key_ff;
      xprev_in      = xprev_ff;
      row_in        = row_ff;
      exact_in      = exact_ff;
      flag_in       = flag_ff;
      idx_in        = idx_ff;
      num_in        = num_ff;
      den_in        = den_ff;
      ya_in         = ya_ff;
      y_in          = y_ff;
      t_in          = t_ff;
      p_in          = p_ff;
      m_in          = m_ff;
      dneg_in       = dneg_ff;
      rsp_strobe_in = 1'b0;
      rsp_value_in  = rsp_value_ff;
      rsp_oor_in    = rsp_oor_ff;
      md_start      = 1'b0;
      fx_start      = 1'b0;
      unique case (state_ff)
         sti_pkg::ST_IDLE: begin
            if (accept && (req_func == sti_pkg::FUNC_QUERY)) begin
               kc_in   = req_key_is_pressure;
               code_in = req_property_code;
               key_in  = req_key_value;
               flag_in = 1'b0;
               idx_in  = '0;
               if (req_property_code > sti_pkg::CODE_LAST) begin
                  rsp_strobe_in = 1'b1;
                  rsp_value_in  = '0;
                  rsp_oor_in    = 1'b1;
               end else begin
                  state_in = sti_pkg::ST_X0_RD;
               end
            end
         end
         sti_pkg::ST_X0_RD: state_in = sti_pkg::ST_X0_CK;
         sti_pkg::ST_X0_CK: begin
            if (key_ff < x_rd) begin
               // below the table: zero and flag
               rsp_strobe_in = 1'b1;
               rsp_value_in  = '0;
               rsp_oor_in    = 1'b1;
               state_in      = sti_pkg::ST_IDLE;
            end else if (key_ff == x_rd) begin
               exact_in = 1'b1;
               row_in   = '0;
               state_in = sti_pkg::ST_STEP;
            end else begin
               xprev_in = x_rd;
               state_in = sti_pkg::ST_XL_RD;
            end
         end
         sti_pkg::ST_XL_RD: state_in = sti_pkg::ST_XL_CK;
         sti_pkg::ST_XL_CK: begin
            if (key_ff >= x_rd) begin
               // at or above the last key: last row, flagged when above
               exact_in = 1'b1;
               row_in   = last_row;
               flag_in  = (key_ff != x_rd);
               state_in = sti_pkg::ST_STEP;
            end else begin
               row_in   = RB'(1);
               state_in = sti_pkg::ST_SCAN_RD;
            end
         end
         sti_pkg::ST_SCAN_RD: state_in = sti_pkg::ST_SCAN_CK;
         sti_pkg::ST_SCAN_CK: begin
            if (key_ff == x_rd) begin
               exact_in = 1'b1;
               state_in = sti_pkg::ST_STEP;
            end else if (key_ff < x_rd) begin
               if (key_ff <= xprev_ff) begin
                  exact_in = 1'b1;
                  row_in   = row_ff - RB'(1);
               end else begin
                  exact_in = 1'b0;
                  num_in   = {key_ff[W-1], key_ff} - {xprev_ff[W-1], xprev_ff};
                  den_in   = {x_rd[W-1], x_rd} - {xprev_ff[W-1], xprev_ff};
               end
               state_in = sti_pkg::ST_STEP;
            end else if (row_ff == last_row) begin
               exact_in = 1'b1;
               state_in = sti_pkg::ST_STEP;
            end else begin
               xprev_in = x_rd;
               row_in   = row_ff + RB'(1);
               state_in = sti_pkg::ST_SCAN_RD;
            end
         end
         sti_pkg::ST_STEP: state_in = sti_pkg::ST_YA;
         sti_pkg::ST_YA: begin
            if (exact_ff) begin
               y_in     = tbl_rd_data;
               state_in = sti_pkg::ST_APPLY;
            end else begin
               ya_in    = tbl_rd_data;
               state_in = sti_pkg::ST_YB;
            end
         end
         sti_pkg::ST_YB: begin
            dneg_in  = dy[MW-1];
            md_start = 1'b1;
            state_in = sti_pkg::ST_DIV;
         end
         sti_pkg::ST_DIV: begin
            if (md_done) begin
               y_in     = dneg_ff ? (ya_ff - md_quot[W-1:0]) : (ya_ff + md_quot[W-1:0]);
               state_in = sti_pkg::ST_APPLY;
            end
         end
         sti_pkg::ST_APPLY: begin
            case (step.op) inside
               sti_pkg::OP_T,
               sti_pkg::OP_ENT: t_in = op_res;
               sti_pkg::OP_P:   p_in = y_ff;
               default:         t_in = t_ff;
            endcase
            if (step.op == sti_pkg::OP_MUL) begin
               fx_start = 1'b1;
               state_in = sti_pkg::ST_MUL;
            end else if (step.last) begin
               rsp_strobe_in = 1'b1;
               rsp_value_in  = op_res;
               rsp_oor_in    = flag_ff;
               state_in      = sti_pkg::ST_IDLE;
            end else begin
               idx_in   = idx_ff + 3'd1;
               state_in = sti_pkg::ST_STEP;
            end
         end
         sti_pkg::ST_MUL: begin
            if (fx_done) begin
               m_in     = fx_prod;
               idx_in   = idx_ff + 3'd1;
               state_in = sti_pkg::ST_STEP;
            end
         end
         default: state_in = sti_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= sti_pkg::ST_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      kc_ff        <= kc_in;
      code_ff      <= code_in;
      key_ff       <= key_in;
      xprev_ff     <= xprev_in;
      row_ff       <= row_in;
      exact_ff     <= exact_in;
      flag_ff      <= flag_in;
      idx_ff       <= idx_in;
      num_ff       <= num_in;
      den_ff       <= den_in;
      ya_ff        <= ya_in;
      y_ff         <= y_in;
      t_ff         <= t_in;
      p_ff         <= p_in;
      m_ff         <= m_in;
      dneg_ff      <= dneg_in;
      rsp_value_ff <= rsp_value_in;
      rsp_oor_ff   <= rsp_oor_in;
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_property_value = rsp_value_ff;
   assign rsp_out_of_range   = rsp_oor_ff;

endmodule

`default_nettype wire
